// File: rtl/core/tws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tws_pkg
// shared types and constants of the two-waypoint shortest route block
// ----------------------------------------------------------------------------
package tws_pkg;

    localparam int NODES_DEF       = 16;
    localparam int MAX_EDGES_DEF   = 256;
    localparam int WEIGHT_BITS_DEF = 16;

    localparam int NODE_FIELD_W   = 4;
    localparam int WEIGHT_FIELD_W = 16;
    localparam int COST_W         = 22;
    localparam logic [COST_W-1:0] COST_MAX = 22'h3FFFFF;

    localparam int LEG_COUNT = 5;
    localparam int LEG_W     = 3;

    typedef enum logic [LEG_W-1:0] {
        LEG_SA = 3'd0,
        LEG_SB = 3'd1,
        LEG_AB = 3'd2,
        LEG_AE = 3'd3,
        LEG_BE = 3'd4
    } leg_t;

    localparam logic MODE_EDGE  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef enum logic [1:0] {
        KIND_COST     = 2'd0,
        KIND_NODE     = 2'd1,
        KIND_FULL     = 2'd2,
        KIND_NO_ROUTE = 2'd3
    } kind_t;

endpackage

// File: rtl/core/tws_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tws_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module tws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/two_waypoint_shortest_route.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_waypoint_shortest_route
// edge store plus five dijkstra searches on one shared scan/relax unit,
// then the cheaper waypoint order is streamed out node by node
// ----------------------------------------------------------------------------
//  channel  handshake             payload
//  in       in_valid / in_ready   mode node_a node_b weight via_first via_second
//  out      out_valid / out_ready kind total_cost path_node last
//
//  an edge item is stored on acceptance; a query runs five searches, each
//  visit being a min scan over all NODES nodes, one visit state and a
//  relaxation pass over the stored edges through the edge ram port, then
//  a request and a data state per route node for the predecessor walk
//  and one output state per emitted item
//  reset clears control state only; the edge ram holds no reset
//  in_ready is low while a query runs; output stalls hold the sequencer
// ----------------------------------------------------------------------------
module two_waypoint_shortest_route #(
    parameter int NODES       = tws_pkg::NODES_DEF,
    parameter int MAX_EDGES   = tws_pkg::MAX_EDGES_DEF,
    parameter int WEIGHT_BITS = tws_pkg::WEIGHT_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic [3:0]  node_a,
    input  logic [3:0]  node_b,
    input  logic [15:0] weight,
    input  logic [3:0]  via_first,
    input  logic [3:0]  via_second,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [21:0] total_cost,
    output logic [3:0]  path_node,
    output logic        last
);

    localparam int NODE_W = $clog2(NODES);
    localparam int DIST_W = WEIGHT_BITS + NODE_W;
    localparam int SUM_W  = DIST_W + 2;
    localparam int CNT_W  = $clog2(MAX_EDGES + 1);
    localparam int EA_W   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int EDGE_W = 2 * NODE_W + WEIGHT_BITS;
    localparam int PA_W   = tws_pkg::LEG_W + NODE_W;
    localparam int PDEPTH = tws_pkg::LEG_COUNT << NODE_W;
    localparam int BUF_D  = NODES + 1;
    localparam int BUF_W  = $clog2(BUF_D);
    localparam int BN_W   = BUF_W + 1;

    typedef enum logic [12:0] {
        S_IDLE      = 13'b0000000000001,
        S_INIT      = 13'b0000000000010,
        S_MIN       = 13'b0000000000100,
        S_VISIT     = 13'b0000000001000,
        S_EDGE      = 13'b0000000010000,
        S_SUM       = 13'b0000000100000,
        S_TOTAL     = 13'b0000001000000,
        S_COST_OUT  = 13'b0000010000000,
        S_WALK_INIT = 13'b0000100000000,
        S_WALK_REQ  = 13'b0001000000000,
        S_WALK_DATA = 13'b0010000000000,
        S_NODE_OUT  = 13'b0100000000000,
        S_FLAG_OUT  = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]  edge_count_reg, edge_count_next;
    logic [NODE_W-1:0] q_a_reg, q_a_next, q_b_reg, q_b_next;
    logic [NODE_W-1:0] q_x_reg, q_x_next, q_y_reg, q_y_next;
    tws_pkg::leg_t     leg_reg, leg_next;
    logic [NODE_W-1:0] scan_reg, scan_next;
    logic              found_reg, found_next;
    logic [NODE_W-1:0] best_node_reg, best_node_next;
    logic [DIST_W-1:0] best_dist_reg, best_dist_next;
    logic [NODE_W-1:0] cur_reg, cur_next;
    logic [DIST_W-1:0] cd_reg, cd_next;
    logic [CNT_W-1:0]  issue_reg, issue_next;
    logic              pipe_v_reg, pipe_v_next;
    logic [DIST_W:0]   sum_a_reg, sum_a_next, sum_b_reg, sum_b_next;
    logic              order_a_reg, order_a_next;
    logic [1:0]        part_reg, part_next;
    logic [NODE_W-1:0] walk_x_reg, walk_x_next;
    logic [BN_W-1:0]   walk_n_reg, walk_n_next;
    logic [BN_W-1:0]   emit_j_reg, emit_j_next;
    tws_pkg::kind_t    flag_kind_reg, flag_kind_next;

    logic              out_valid_reg, out_valid_next;
    tws_pkg::kind_t    kind_reg, kind_next;
    logic [21:0]       total_cost_reg, total_cost_next;
    logic [3:0]        path_node_reg, path_node_next;
    logic              last_reg, last_next;

    logic [DIST_W-1:0] dist_reg [NODES];
    logic              reached_reg [NODES];
    logic              visited_reg [NODES];
    logic [DIST_W-1:0] seg_cost_reg [tws_pkg::LEG_COUNT];
    logic [NODE_W-1:0] buf_reg [BUF_D];

    logic              flags_clear, visit_set, relax, seg_we, buf_we;
    logic [BUF_W-1:0]  buf_wa;
    logic [NODE_W-1:0] buf_wd;

    logic              edge_we;
    logic [EDGE_W-1:0] edge_wdata, edge_rdata;
    logic [PA_W-1:0]   pred_raddr, pred_waddr;
    logic [NODE_W-1:0] pred_rdata;

    logic [NODE_W-1:0] in_a, in_b, in_x, in_y;
    logic              in_nodes_ok, query_ok, accept, out_free;
    logic [WEIGHT_BITS-1:0] w_in;

    tws_pkg::leg_t     walk_leg, sel_leg;
    logic              walking, walk_rev;
    logic [NODE_W-1:0] src, dst;

    logic [NODE_W-1:0] e_u, e_v, nb;
    logic [WEIGHT_BITS-1:0] e_w;
    logic              hit;
    logic [DIST_W-1:0] nd;
    logic [NODE_W-1:0] dist_ra;
    logic [DIST_W-1:0] dist_rd;
    logic [BN_W-1:0]   emit_cnt, buf_idx;
    logic [SUM_W-1:0]  tot_sum;
    logic [31:0]       tot32;

    // input decode
    assign in_a = NODE_W'(node_a);
    assign in_b = NODE_W'(node_b);
    assign in_x = NODE_W'(via_first);
    assign in_y = NODE_W'(via_second);
    assign w_in = WEIGHT_BITS'(weight);
    assign in_nodes_ok = (32'(node_a) < NODES) && (32'(node_b) < NODES);
    assign query_ok    = in_nodes_ok && (32'(via_first) < NODES)
                         && (32'(via_second) < NODES);
    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // leg endpoints
    assign walking = (state_reg == S_WALK_INIT) || (state_reg == S_WALK_REQ)
                     || (state_reg == S_WALK_DATA) || (state_reg == S_NODE_OUT);
    always_comb
    begin
        unique case (part_reg)
            2'd0:    walk_leg = order_a_reg ? tws_pkg::LEG_SA : tws_pkg::LEG_SB;
            2'd1:    walk_leg = tws_pkg::LEG_AB;
            default: walk_leg = order_a_reg ? tws_pkg::LEG_BE : tws_pkg::LEG_AE;
        endcase
    end
    assign walk_rev = !order_a_reg && (part_reg == 2'd1);
    assign sel_leg  = walking ? walk_leg : leg_reg;

    always_comb
    begin
        unique case (sel_leg)
            tws_pkg::LEG_SA: begin src = q_a_reg; dst = q_x_reg; end
            tws_pkg::LEG_SB: begin src = q_a_reg; dst = q_y_reg; end
            tws_pkg::LEG_AB: begin src = q_x_reg; dst = q_y_reg; end
            tws_pkg::LEG_AE: begin src = q_x_reg; dst = q_b_reg; end
            tws_pkg::LEG_BE: begin src = q_y_reg; dst = q_b_reg; end
            default:         begin src = q_a_reg; dst = q_a_reg; end
        endcase
    end

    // relaxation unit
    assign e_u = edge_rdata[EDGE_W-1 -: NODE_W];
    assign e_v = edge_rdata[WEIGHT_BITS +: NODE_W];
    assign e_w = edge_rdata[WEIGHT_BITS-1:0];
    assign hit = (e_u == cur_reg) || (e_v == cur_reg);
    assign nb  = (e_u == cur_reg) ? e_v : e_u;
    assign nd  = cd_reg + DIST_W'(e_w);
    assign dist_ra = (state_reg == S_MIN) ? scan_reg : nb;
    assign dist_rd = dist_reg[dist_ra];
    assign relax = (state_reg == S_EDGE) && pipe_v_reg && hit && !visited_reg[nb]
                   && (!reached_reg[nb] || (nd < dist_rd));

    assign pred_waddr = {leg_reg, nb};
    assign pred_raddr = {sel_leg, walk_x_reg};

    assign emit_cnt = (part_reg == 2'd2) ? walk_n_reg : (walk_n_reg - BN_W'(1));
    assign buf_idx  = walk_rev ? emit_j_reg : (walk_n_reg - BN_W'(1) - emit_j_reg);

    assign tot_sum = (order_a_reg ? SUM_W'(sum_a_reg) : SUM_W'(sum_b_reg))
                     + SUM_W'(seg_cost_reg[tws_pkg::LEG_AB]);
    assign tot32   = 32'(tot_sum);

    assign edge_wdata = {in_a, in_b, w_in};

    always_comb
    begin
        state_next      = state_reg;
        edge_count_next = edge_count_reg;
        q_a_next        = q_a_reg;
        q_b_next        = q_b_reg;
        q_x_next        = q_x_reg;
        q_y_next        = q_y_reg;
        leg_next        = leg_reg;
        scan_next       = scan_reg;
        found_next      = found_reg;
        best_node_next  = best_node_reg;
        best_dist_next  = best_dist_reg;
        cur_next        = cur_reg;
        cd_next         = cd_reg;
        issue_next      = issue_reg;
        pipe_v_next     = 1'b0;
        sum_a_next      = sum_a_reg;
        sum_b_next      = sum_b_reg;
        order_a_next    = order_a_reg;
        part_next       = part_reg;
        walk_x_next     = walk_x_reg;
        walk_n_next     = walk_n_reg;
        emit_j_next     = emit_j_reg;
        flag_kind_next  = flag_kind_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        kind_next       = kind_reg;
        total_cost_next = total_cost_reg;
        path_node_next  = path_node_reg;
        last_next       = last_reg;
        flags_clear     = 1'b0;
        visit_set       = 1'b0;
        seg_we          = 1'b0;
        buf_we          = 1'b0;
        buf_wa          = '0;
        buf_wd          = walk_x_reg;
        edge_we         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (mode == tws_pkg::MODE_EDGE)
                    begin
                        if (in_nodes_ok)
                        begin
                            if (32'(edge_count_reg) >= MAX_EDGES)
                            begin
                                flag_kind_next = tws_pkg::KIND_FULL;
                                state_next     = S_FLAG_OUT;
                            end
                            else
                            begin
                                edge_we         = 1'b1;
                                edge_count_next = edge_count_reg + CNT_W'(1);
                            end
                        end
                    end
                    else if (!query_ok)
                    begin
                        flag_kind_next = tws_pkg::KIND_NO_ROUTE;
                        state_next     = S_FLAG_OUT;
                    end
                    else
                    begin
                        q_a_next   = in_a;
                        q_b_next   = in_b;
                        q_x_next   = in_x;
                        q_y_next   = in_y;
                        leg_next   = tws_pkg::LEG_SA;
                        state_next = S_INIT;
                    end
                end
            end
            S_INIT:
            begin
                flags_clear = 1'b1;
                scan_next   = '0;
                found_next  = 1'b0;
                state_next  = S_MIN;
            end
            S_MIN:
            begin
                if (!visited_reg[scan_reg] && reached_reg[scan_reg]
                    && (!found_reg || (dist_rd < best_dist_reg)))
                begin
                    found_next     = 1'b1;
                    best_node_next = scan_reg;
                    best_dist_next = dist_rd;
                end
                if (scan_reg == NODE_W'(NODES - 1))
                begin
                    state_next = S_VISIT;
                end
                else
                begin
                    scan_next = scan_reg + NODE_W'(1);
                end
            end
            S_VISIT:
            begin
                if (!found_reg)
                begin
                    flag_kind_next = tws_pkg::KIND_NO_ROUTE;
                    state_next     = S_FLAG_OUT;
                end
                else
                begin
                    visit_set = 1'b1;
                    cur_next  = best_node_reg;
                    cd_next   = best_dist_reg;
                    if (best_node_reg == dst)
                    begin
                        seg_we = 1'b1;
                        if (leg_reg == tws_pkg::LEG_BE)
                        begin
                            state_next = S_SUM;
                        end
                        else
                        begin
                            leg_next   = tws_pkg::leg_t'(leg_reg + tws_pkg::LEG_W'(1));
                            state_next = S_INIT;
                        end
                    end
                    else
                    begin
                        issue_next = '0;
                        state_next = S_EDGE;
                    end
                end
            end
            S_EDGE:
            begin
                if (issue_reg < edge_count_reg)
                begin
                    issue_next  = issue_reg + CNT_W'(1);
                    pipe_v_next = 1'b1;
                end
                else if (!pipe_v_reg)
                begin
                    scan_next  = '0;
                    found_next = 1'b0;
                    state_next = S_MIN;
                end
            end
            S_SUM:
            begin
                sum_a_next = (DIST_W+1)'(seg_cost_reg[tws_pkg::LEG_SA])
                             + (DIST_W+1)'(seg_cost_reg[tws_pkg::LEG_BE]);
                sum_b_next = (DIST_W+1)'(seg_cost_reg[tws_pkg::LEG_SB])
                             + (DIST_W+1)'(seg_cost_reg[tws_pkg::LEG_AE]);
                state_next = S_TOTAL;
            end
            S_TOTAL:
            begin
                order_a_next = sum_a_reg < sum_b_reg;
                state_next   = S_COST_OUT;
            end
            S_COST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    kind_next       = tws_pkg::KIND_COST;
                    total_cost_next = (tot32 > 32'(tws_pkg::COST_MAX))
                                      ? tws_pkg::COST_MAX : tot32[21:0];
                    path_node_next  = '0;
                    last_next       = 1'b0;
                    part_next       = 2'd0;
                    state_next      = S_WALK_INIT;
                end
            end
            S_WALK_INIT:
            begin
                walk_x_next = dst;
                buf_we      = 1'b1;
                buf_wa      = '0;
                buf_wd      = dst;
                walk_n_next = BN_W'(1);
                state_next  = S_WALK_REQ;
            end
            S_WALK_REQ:
            begin
                if ((walk_x_reg == src) || (32'(walk_n_reg) == NODES + 1))
                begin
                    emit_j_next = '0;
                    if (emit_cnt == '0)
                    begin
                        part_next  = part_reg + 2'd1;
                        state_next = S_WALK_INIT;
                    end
                    else
                    begin
                        state_next = S_NODE_OUT;
                    end
                end
                else
                begin
                    state_next = S_WALK_DATA;
                end
            end
            S_WALK_DATA:
            begin
                walk_x_next = pred_rdata;
                buf_we      = 1'b1;
                buf_wa      = walk_n_reg[BUF_W-1:0];
                buf_wd      = pred_rdata;
                walk_n_next = walk_n_reg + BN_W'(1);
                state_next  = S_WALK_REQ;
            end
            S_NODE_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    kind_next       = tws_pkg::KIND_NODE;
                    total_cost_next = '0;
                    path_node_next  = 4'(buf_reg[buf_idx[BUF_W-1:0]]);
                    last_next       = (part_reg == 2'd2)
                                      && (emit_j_reg == emit_cnt - BN_W'(1));
                    if (emit_j_reg == emit_cnt - BN_W'(1))
                    begin
                        if (part_reg == 2'd2)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            part_next  = part_reg + 2'd1;
                            state_next = S_WALK_INIT;
                        end
                    end
                    else
                    begin
                        emit_j_next = emit_j_reg + BN_W'(1);
                    end
                end
            end
            S_FLAG_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    kind_next       = flag_kind_reg;
                    total_cost_next = '0;
                    path_node_next  = '0;
                    last_next       = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            edge_count_reg <= '0;
            pipe_v_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            leg_reg        <= tws_pkg::LEG_SA;
            part_reg       <= 2'd0;
        end
        else
        begin
            state_reg      <= state_next;
            edge_count_reg <= edge_count_next;
            pipe_v_reg     <= pipe_v_next;
            out_valid_reg  <= out_valid_next;
            leg_reg        <= leg_next;
            part_reg       <= part_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_a_reg        <= q_a_next;
        q_b_reg        <= q_b_next;
        q_x_reg        <= q_x_next;
        q_y_reg        <= q_y_next;
        scan_reg       <= scan_next;
        found_reg      <= found_next;
        best_node_reg  <= best_node_next;
        best_dist_reg  <= best_dist_next;
        cur_reg        <= cur_next;
        cd_reg         <= cd_next;
        issue_reg      <= issue_next;
        sum_a_reg      <= sum_a_next;
        sum_b_reg      <= sum_b_next;
        order_a_reg    <= order_a_next;
        walk_x_reg     <= walk_x_next;
        walk_n_reg     <= walk_n_next;
        emit_j_reg     <= emit_j_next;
        flag_kind_reg  <= flag_kind_next;
        kind_reg       <= kind_next;
        total_cost_reg <= total_cost_next;
        path_node_reg  <= path_node_next;
        last_reg       <= last_next;
        if (flags_clear)
        begin
            dist_reg[src] <= '0;
        end
        else if (relax)
        begin
            dist_reg[nb] <= nd;
        end
        if (seg_we)
        begin
            seg_cost_reg[leg_reg] <= best_dist_reg;
        end
        if (buf_we)
        begin
            buf_reg[buf_wa] <= buf_wd;
        end
    end

    // search flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NODES; i++)
            begin
                reached_reg[i] <= 1'b0;
                visited_reg[i] <= 1'b0;
            end
        end
        else if (flags_clear)
        begin
            for (int i = 0; i < NODES; i++)
            begin
                reached_reg[i] <= (NODE_W'(i) == src);
                visited_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (visit_set)
            begin
                visited_reg[best_node_reg] <= 1'b1;
            end
            if (relax)
            begin
                reached_reg[nb] <= 1'b1;
            end
        end
    end

    tws_ram #(
        .WIDTH (EDGE_W),
        .DEPTH (MAX_EDGES),
        .ADDR_W(EA_W)
    ) u_edge_ram (
        .clk  (clk),
        .we   (edge_we),
        .waddr(edge_count_reg[EA_W-1:0]),
        .wdata(edge_wdata),
        .raddr(issue_reg[EA_W-1:0]),
        .rdata(edge_rdata)
    );

    tws_ram #(
        .WIDTH (NODE_W),
        .DEPTH (PDEPTH),
        .ADDR_W(PA_W)
    ) u_pred_ram (
        .clk  (clk),
        .we   (relax),
        .waddr(pred_waddr),
        .wdata(cur_reg),
        .raddr(pred_raddr),
        .rdata(pred_rdata)
    );

    assign out_valid  = out_valid_reg;
    assign kind       = kind_reg;
    assign total_cost = total_cost_reg;
    assign path_node  = path_node_reg;
    assign last       = last_reg;

    // a query keeps the input closed on the next cycle
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (mode == tws_pkg::MODE_QUERY)) |=> !in_ready)
        else $error("input open right after a query");

    // relax pipeline only runs inside the edge scan
    a_pipe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        pipe_v_reg |-> (state_reg == S_EDGE))
        else $error("edge pipeline valid outside edge scan");

    // edge count never passes capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(edge_count_reg) <= MAX_EDGES)
        else $error("edge count beyond capacity");

    // a cost item is never the final item of a query
    a_cost_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (kind_reg == tws_pkg::KIND_COST)) |-> !last_reg)
        else $error("cost item marked last");

endmodule
